// ===== rtl/nsbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsbs_pkg: shared types and constants for the nonce hashing core
// Round constants, initial hash value, register codes and control struct.
// ----------------------------------------------------------------------------
package nsbs_pkg;

    localparam int WORD_W       = 32;
    localparam int NUM_PFX_REGS = 6;
    localparam int ROUNDS       = 64;
    localparam int ROUND_W      = $clog2(ROUNDS);

    localparam logic [5:0] MAX_PREFIX_BYTES = 6'd47;

    // configuration register codes
    localparam logic [2:0] CFG_PFX0 = 3'd0;
    localparam logic [2:0] CFG_PFX1 = 3'd1;
    localparam logic [2:0] CFG_PFX2 = 3'd2;
    localparam logic [2:0] CFG_PFX3 = 3'd3;
    localparam logic [2:0] CFG_PFX4 = 3'd4;
    localparam logic [2:0] CFG_PFX5 = 3'd5;
    localparam logic [2:0] CFG_LEN  = 3'd6;

    typedef logic [NUM_PFX_REGS-1:0][63:0] t_prefix;
    typedef logic [15:0][WORD_W-1:0]       t_block;
    typedef logic [7:0][WORD_W-1:0]        t_hash;

    typedef struct packed {
        logic load;
        logic step;
    } t_ctrl;

    localparam logic [WORD_W-1:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ===== rtl/nonce_single_block_sha256_top.sv =====
`timescale 1ns / 1ps
// An accepted nonce loads the schedule and working state; ST_RUN then steps
// the single shared round unit, one round per cycle, and ST_FIN registers the
// digest once the result register is free. No new nonce is taken until then.
// The result register frees the input side while a digest waits downstream.
// Reset: synchronous active-low i_rst_n clears control, output valid and
// all configuration registers (prefix and length read as zero).
// ----------------------------------------------------------------------------
// nonce_single_block_sha256_top: nonce hashing core, top level
// Config registers, round sequencer, schedule and round unit, result register.
// ----------------------------------------------------------------------------
module nonce_single_block_sha256_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    // nonce requests
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [63:0]  i_s_axis_tdata,   // [63:0] nonce_value
    // digests
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [255:0] o_m_axis_tdata    // [63:0] digest_bits_255_192,
                                           // [127:64] digest_bits_191_128,
                                           // [191:128] digest_bits_127_64,
                                           // [255:192] digest_bits_63_0
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    t_state                               r_state;
    t_state                               n_state;
    logic [nsbs_pkg::ROUND_W-1:0]         r_round;
    logic [nsbs_pkg::ROUND_W-1:0]         n_round;
    logic                                 r_out_valid;
    logic                                 n_out_valid;
    logic [255:0]                         r_out_data;
    nsbs_pkg::t_prefix                    r_prefix;
    logic [5:0]                           r_len;
    nsbs_pkg::t_ctrl                      ctrl;
    nsbs_pkg::t_block                     block;
    nsbs_pkg::t_hash                      digest;
    logic [nsbs_pkg::WORD_W-1:0]          sched_w;
    logic                                 in_req;
    logic                                 out_load;

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= '0;
            r_len    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nsbs_pkg::CFG_PFX0: r_prefix[0] <= i_cfg_data;
                nsbs_pkg::CFG_PFX1: r_prefix[1] <= i_cfg_data;
                nsbs_pkg::CFG_PFX2: r_prefix[2] <= i_cfg_data;
                nsbs_pkg::CFG_PFX3: r_prefix[3] <= i_cfg_data;
                nsbs_pkg::CFG_PFX4: r_prefix[4] <= i_cfg_data;
                nsbs_pkg::CFG_PFX5: r_prefix[5] <= i_cfg_data;
                nsbs_pkg::CFG_LEN:  r_len       <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // sequencer
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_req          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load        = (r_state == ST_FIN) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_out_valid = r_out_valid;
        ctrl.load   = 1'b0;
        ctrl.step   = 1'b0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_req) begin
                    ctrl.load = 1'b1;
                    n_round   = '0;
                    n_state   = ST_RUN;
                end
            end
            ST_RUN: begin
                ctrl.step = 1'b1;
                n_round   = r_round + 1'b1;
                if (r_round == nsbs_pkg::ROUND_W'(nsbs_pkg::ROUNDS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int k = 0; k < 4; k++) begin
                r_out_data[64*k +: 64] <= {digest[2*k], digest[2*k+1]};
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    nsbs_msg u_msg (
        .i_prefix (r_prefix),
        .i_len    (r_len),
        .i_nonce  (i_s_axis_tdata),
        .o_block  (block)
    );

    nsbs_sched u_sched (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl),
        .i_block (block),
        .o_w     (sched_w)
    );

    nsbs_round u_round (
        .i_clk    (i_clk),
        .i_ctrl   (ctrl),
        .i_k      (nsbs_pkg::ROUND_K[r_round]),
        .i_w      (sched_w),
        .o_digest (digest)
    );

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_req |=> (r_state == ST_RUN) && (r_round == '0))
        else $error("round sequence did not start on request");

    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) && (r_round == nsbs_pkg::ROUND_W'(nsbs_pkg::ROUNDS - 1))
        |=> (r_state == ST_FIN))
        else $error("final round did not lead to finish");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_m_axis_tvalid && (r_state == ST_IDLE))
        else $error("digest not presented after finish");

endmodule

// ===== rtl/nsbs_msg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsbs_msg: message block builder
// Places prefix, little-endian nonce, pad byte and bit length in one block.
// ----------------------------------------------------------------------------
module nsbs_msg (
    input  nsbs_pkg::t_prefix i_prefix,
    input  logic [5:0]        i_len,
    input  logic [63:0]       i_nonce,
    output nsbs_pkg::t_block  o_block
);

    logic [5:0]        plen;
    logic [5:0]        total;
    logic [8:0]        bit_len;
    logic [6:0]        off;
    logic [47:0][7:0]  pbytes;
    logic [63:0][7:0]  bytes;

    always_comb begin
        plen    = (i_len > nsbs_pkg::MAX_PREFIX_BYTES) ? nsbs_pkg::MAX_PREFIX_BYTES : i_len;
        total   = plen + 6'd8;
        bit_len = {total, 3'b000};
        off     = '0;

        for (int r = 0; r < nsbs_pkg::NUM_PFX_REGS; r++) begin
            for (int b = 0; b < 8; b++) begin
                pbytes[8*r+b] = i_prefix[r][63-8*b -: 8];
            end
        end

        bytes = '0;
        for (int i = 0; i < 48; i++) begin
            if (6'(i) < plen) begin
                bytes[i] = pbytes[i];
            end
        end
        // offset wraps high for bytes ahead of the nonce
        for (int i = 0; i < 64; i++) begin
            off = 7'(i) - {1'b0, plen};
            if (off[6:3] == 4'd0) begin
                bytes[i] = i_nonce[8*off[2:0] +: 8];
            end else if (off == 7'd8) begin
                bytes[i] = 8'h80;
            end
        end
        bytes[62] = {7'b0, bit_len[8]};
        bytes[63] = bit_len[7:0];

        for (int t = 0; t < 16; t++) begin
            o_block[t] = {bytes[4*t], bytes[4*t+1], bytes[4*t+2], bytes[4*t+3]};
        end
    end

endmodule

// ===== rtl/nsbs_sched.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsbs_sched: message schedule
// 16-word shift window; emits one schedule word per round step.
// ----------------------------------------------------------------------------
module nsbs_sched (
    input  logic                          i_clk,
    input  nsbs_pkg::t_ctrl               i_ctrl,
    input  nsbs_pkg::t_block              i_block,
    output logic [nsbs_pkg::WORD_W-1:0]   o_w
);

    nsbs_pkg::t_block               r_w;
    nsbs_pkg::t_block               n_w;
    logic [nsbs_pkg::WORD_W-1:0]    s0;
    logic [nsbs_pkg::WORD_W-1:0]    s1;
    logic [nsbs_pkg::WORD_W-1:0]    w_new;

    always_comb begin
        s0 = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3);
        s1 = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
           ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];

        n_w = r_w;
        if (i_ctrl.load) begin
            n_w = i_block;
        end else if (i_ctrl.step) begin
            for (int j = 0; j < 15; j++) begin
                n_w[j] = r_w[j+1];
            end
            n_w[15] = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
    end

    assign o_w = r_w[0];

endmodule

// ===== rtl/nsbs_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsbs_round: compression round unit
// Working variables a..h, one round per step, final add of the initial value.
// ----------------------------------------------------------------------------
module nsbs_round (
    input  logic                          i_clk,
    input  nsbs_pkg::t_ctrl               i_ctrl,
    input  logic [nsbs_pkg::WORD_W-1:0]   i_k,
    input  logic [nsbs_pkg::WORD_W-1:0]   i_w,
    output nsbs_pkg::t_hash               o_digest
);

    nsbs_pkg::t_hash                r_s;
    nsbs_pkg::t_hash                n_s;
    logic [nsbs_pkg::WORD_W-1:0]    sum0;
    logic [nsbs_pkg::WORD_W-1:0]    sum1;
    logic [nsbs_pkg::WORD_W-1:0]    choose;
    logic [nsbs_pkg::WORD_W-1:0]    major;
    logic [nsbs_pkg::WORD_W-1:0]    x1;

    always_comb begin
        sum1   = {r_s[4][5:0], r_s[4][31:6]} ^ {r_s[4][10:0], r_s[4][31:11]}
               ^ {r_s[4][24:0], r_s[4][31:25]};
        choose = (r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]);
        x1     = r_s[7] + sum1 + choose + i_k + i_w;
        sum0   = {r_s[0][1:0], r_s[0][31:2]} ^ {r_s[0][12:0], r_s[0][31:13]}
               ^ {r_s[0][21:0], r_s[0][31:22]};
        major  = (r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]);

        n_s = r_s;
        if (i_ctrl.load) begin
            for (int j = 0; j < 8; j++) begin
                n_s[j] = nsbs_pkg::HASH_IV[j];
            end
        end else if (i_ctrl.step) begin
            n_s[7] = r_s[6];
            n_s[6] = r_s[5];
            n_s[5] = r_s[4];
            n_s[4] = r_s[3] + x1;
            n_s[3] = r_s[2];
            n_s[2] = r_s[1];
            n_s[1] = r_s[0];
            n_s[0] = x1 + sum0 + major;
        end

        for (int j = 0; j < 8; j++) begin
            o_digest[j] = nsbs_pkg::HASH_IV[j] + r_s[j];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
    end

endmodule
